### src/tcal_pkg.sv
// ============================================================================
// tcal_pkg
// Shared types and constants of the thresholded class argmax labeler: the
// configuration view that the lanes see, the per-lane tag and register codes.
// ============================================================================
package tcal_pkg;

    // Width of the label and of the class count and rank fields.
    localparam int LABEL_W = 4;
    // Width of the ignore mask register.
    localparam int IGN_W   = 8;
    // Data width of the configuration port.
    localparam int CFG_W   = 32;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_CLASS_COUNT = 2'd1,
        REG_BACKGROUND  = 2'd2,
        REG_IGNORE_MASK = 2'd3
    } reg_idx_t;

    // Configuration as the lanes use it.
    typedef struct packed {
        logic [LABEL_W-1:0] n_eff;       // class count clamped to the lane count
        logic               first;       // first scanned class (0 or 1)
        logic [IGN_W-1:0]   ignore_mask;
    } lane_cfg_t;

    // What one lane found for its class.
    typedef struct packed {
        logic               cand;        // in range, not ignored, above threshold
        logic [LABEL_W-1:0] rank;        // non-ignored classes below this one
    } lane_tag_t;

endpackage

### src/thresholded_class_argmax_labeler_top.sv
// An accepted request's label reaches m_tvalid via the lane and output registers.
// Throughput: one pixel per cycle unless m_tready stalls; every class has its
// own lane, and the merging tree and output register take an item each cycle.
// Reset: aresetn (synchronous, active low) empties the pipeline and returns
// the registers to threshold 16384, class_count 8, background 0, mask 0.
// ============================================================================
// thresholded_class_argmax_labeler_top
// Per-pixel labeler: one lane per class tests its score, a merging stage
// picks the winner, and an APB-style port holds the configuration.
// ============================================================================
module thresholded_class_argmax_labeler_top #(
    parameter int MAX_CLASSES = 8,
    parameter int SCORE_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input pixel channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: score_0 .. score_(MAX_CLASSES-1), SCORE_WIDTH bits each, from bit 0 up
    input  logic [((MAX_CLASSES*SCORE_WIDTH+7)/8)*8-1:0] s_tdata,
    // Label channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: label [3:0], zeros above
    output logic [7:0]                   m_tdata,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [tcal_pkg::CFG_W-1:0]   pwdata,
    output logic [tcal_pkg::CFG_W-1:0]   prdata,
    output logic                         pready
);

    logic signed [SCORE_WIDTH-1:0]  threshold_reg;
    logic [tcal_pkg::LABEL_W-1:0]   class_count_reg;
    logic                           background_reg;
    logic [tcal_pkg::IGN_W-1:0]     ignore_mask_reg;

    logic                           cfg_write;
    tcal_pkg::reg_idx_t             cfg_idx;
    tcal_pkg::lane_cfg_t            lane_cfg;

    logic                           v1_reg;
    logic                           v1_next;
    logic                           m_tvalid_reg;
    logic                           m_tvalid_next;
    logic                           ready2;
    logic                           load1;
    logic                           move2;

    logic signed [SCORE_WIDTH-1:0]  score_in   [MAX_CLASSES];
    logic signed [SCORE_WIDTH-1:0]  lane_score [MAX_CLASSES];
    tcal_pkg::lane_tag_t            lane_tag   [MAX_CLASSES];
    logic signed [SCORE_WIDTH-1:0]  score0_reg;
    logic                           offset_reg;
    logic [tcal_pkg::LABEL_W-1:0]   label_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = tcal_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= SCORE_WIDTH'(16384);
            class_count_reg <= tcal_pkg::LABEL_W'(8);
            background_reg  <= 1'b0;
            ignore_mask_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_idx)
                tcal_pkg::REG_THRESHOLD:   threshold_reg   <= pwdata[SCORE_WIDTH-1:0];
                tcal_pkg::REG_CLASS_COUNT: class_count_reg <= pwdata[tcal_pkg::LABEL_W-1:0];
                tcal_pkg::REG_BACKGROUND:  background_reg  <= pwdata[0];
                tcal_pkg::REG_IGNORE_MASK: ignore_mask_reg <= pwdata[tcal_pkg::IGN_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            tcal_pkg::REG_THRESHOLD:   prdata = tcal_pkg::CFG_W'(threshold_reg);
            tcal_pkg::REG_CLASS_COUNT: prdata = tcal_pkg::CFG_W'(class_count_reg);
            tcal_pkg::REG_BACKGROUND:  prdata = tcal_pkg::CFG_W'(background_reg);
            tcal_pkg::REG_IGNORE_MASK: prdata = tcal_pkg::CFG_W'(ignore_mask_reg);
            default:                   prdata = '0;
        endcase
    end

    // Class count clamped to the lane count; class 0 is skipped only when
    // background is on and more than one class is in use.
    always_comb begin
        lane_cfg.n_eff = (class_count_reg > tcal_pkg::LABEL_W'(MAX_CLASSES))
                         ? tcal_pkg::LABEL_W'(MAX_CLASSES) : class_count_reg;
        lane_cfg.first = background_reg && (lane_cfg.n_eff > tcal_pkg::LABEL_W'(1));
        lane_cfg.ignore_mask = ignore_mask_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control: lane stage, then output register
    // ------------------------------------------------------------------
    assign ready2   = !m_tvalid_reg || m_tready;
    assign s_tready = !v1_reg || ready2;
    assign load1    = s_tvalid && s_tready;
    assign move2    = v1_reg && ready2;

    always_comb begin
        v1_next = v1_reg;
        if (load1) begin
            v1_next = 1'b1;
        end else if (move2) begin
            v1_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (move2) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            v1_reg       <= v1_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Class 0's score and the label offset travel beside the lanes.
    always_ff @(posedge aclk) begin
        if (load1) begin
            score0_reg <= score_in[0];
            offset_reg <= !lane_cfg.first;
        end
    end

    // ------------------------------------------------------------------
    // Class lanes
    // ------------------------------------------------------------------
    generate
        for (genvar j = 0; j < MAX_CLASSES; j++) begin : g_lane
            assign score_in[j] = s_tdata[j*SCORE_WIDTH +: SCORE_WIDTH];

            tcal_lane #(
                .LANE_IDX    (j),
                .SCORE_WIDTH (SCORE_WIDTH)
            ) u_lane (
                .aclk      (aclk),
                .load      (load1),
                .score_in  (score_in[j]),
                .threshold (threshold_reg),
                .cfg       (lane_cfg),
                .score_reg (lane_score[j]),
                .tag_reg   (lane_tag[j])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Merging stage
    // ------------------------------------------------------------------
    tcal_merge #(
        .MAX_CLASSES (MAX_CLASSES),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_merge (
        .aclk       (aclk),
        .load       (move2),
        .lane_score (lane_score),
        .lane_tag   (lane_tag),
        .score0     (score0_reg),
        .offset     (offset_reg),
        .label_reg  (label_reg)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 8'(label_reg);

`ifndef SYNTH
    // A label never exceeds the number of classes.
    a_label_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= 8'(MAX_CLASSES)))
        else $error("label out of range");

    // An accepted request occupies the lane stage in the next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted request lost at lane stage");

    // A lane stage item that cannot move stays put.
    a_lane_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !ready2 && !load1) |=> v1_reg)
        else $error("lane stage item dropped while stalled");

    // Input backpressure only when both stages are full and the output stalls.
    a_ready_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // A move into the output register always presents a label next cycle.
    a_move_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        move2 |=> m_tvalid)
        else $error("label not presented after merge");
`endif

endmodule

### src/tcal_lane.sv
// ============================================================================
// tcal_lane
// One class lane: decides whether its class may win (in scan range, not
// ignored, above threshold) and computes its rank among non-ignored classes.
// ============================================================================
module tcal_lane #(
    parameter int LANE_IDX    = 0,
    parameter int SCORE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic signed [SCORE_WIDTH-1:0] score_in,
    input  logic signed [SCORE_WIDTH-1:0] threshold,
    input  tcal_pkg::lane_cfg_t           cfg,
    output logic signed [SCORE_WIDTH-1:0] score_reg,
    output tcal_pkg::lane_tag_t           tag_reg
);

    localparam logic [tcal_pkg::LABEL_W-1:0] IDX = tcal_pkg::LABEL_W'(LANE_IDX);

    logic                           ignored;
    logic                           in_range;
    logic [tcal_pkg::LABEL_W-1:0]   rank;
    tcal_pkg::lane_tag_t            tag_next;

    // Mask bits exist only for the low classes; higher classes are never ignored.
    generate
        if (LANE_IDX < tcal_pkg::IGN_W) begin : g_mask
            assign ignored = cfg.ignore_mask[LANE_IDX];
        end else begin : g_nomask
            assign ignored = 1'b0;
        end
    endgenerate

    assign in_range = (IDX >= {{(tcal_pkg::LABEL_W-1){1'b0}}, cfg.first}) &&
                      (IDX < cfg.n_eff);

    // Count the non-ignored classes below this lane.
    always_comb begin
        rank = '0;
        for (int k = 0; k < LANE_IDX; k++) begin
            if (k >= tcal_pkg::IGN_W) begin
                rank = rank + 1'b1;
            end else if (!cfg.ignore_mask[k[2:0]]) begin
                rank = rank + 1'b1;
            end
        end
    end

    always_comb begin
        tag_next.cand = in_range && !ignored && (score_in > threshold);
        tag_next.rank = rank;
    end

    // Lane result register, loaded when a request enters the pipeline.
    always_ff @(posedge aclk) begin
        if (load) begin
            score_reg <= score_in;
            tag_reg   <= tag_next;
        end
    end

endmodule

### src/tcal_merge.sv
// ============================================================================
// tcal_merge
// Merging stage: a compare-select tree picks the highest candidate score,
// later classes winning ties, checks it against class 0's score and forms
// the label in the output register.
// ============================================================================
module tcal_merge #(
    parameter int MAX_CLASSES = 8,
    parameter int SCORE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic signed [SCORE_WIDTH-1:0] lane_score [MAX_CLASSES],
    input  tcal_pkg::lane_tag_t           lane_tag   [MAX_CLASSES],
    input  logic signed [SCORE_WIDTH-1:0] score0,
    input  logic                          offset,
    output logic [tcal_pkg::LABEL_W-1:0]  label_reg
);

    localparam int LEVELS = $clog2(MAX_CLASSES);
    localparam int NP     = 1 << LEVELS;
    localparam int NODES  = 2 * NP - 1;

    logic signed [SCORE_WIDTH-1:0]  node_score [NODES];
    tcal_pkg::lane_tag_t            node_tag   [NODES];
    logic                           found;
    logic [tcal_pkg::LABEL_W-1:0]   label_next;

    // Leaves: lanes in order, unused leaves never win.
    generate
        for (genvar i = 0; i < NP; i++) begin : g_leaf
            if (i < MAX_CLASSES) begin : g_used
                assign node_score[NP-1+i] = lane_score[i];
                assign node_tag[NP-1+i]   = lane_tag[i];
            end else begin : g_pad
                assign node_score[NP-1+i] = '0;
                assign node_tag[NP-1+i]   = '0;
            end
        end

        // Internal nodes: the right child holds the higher classes, so it
        // wins a tie.
        for (genvar n = 0; n < NP - 1; n++) begin : g_node
            logic pick_right;
            assign pick_right = node_tag[2*n+2].cand &&
                                (!node_tag[2*n+1].cand ||
                                 (node_score[2*n+2] >= node_score[2*n+1]));
            assign node_score[n] = pick_right ? node_score[2*n+2] : node_score[2*n+1];
            assign node_tag[n]   = pick_right ? node_tag[2*n+2]   : node_tag[2*n+1];
        end
    endgenerate

    // The running best starts at class 0's score, so the best candidate must
    // also reach that.
    assign found      = node_tag[0].cand && (node_score[0] >= score0);
    assign label_next = found ? (node_tag[0].rank + {{(tcal_pkg::LABEL_W-1){1'b0}}, offset})
                              : '0;

    always_ff @(posedge aclk) begin
        if (load) begin
            label_reg <= label_next;
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the thresholded class argmax labeler
// Streams pixels of eight class scores into the block under several register
// settings. Each accepted request is labeled by a predictor in the driver,
// and each label from the block is compared in order with those predictions.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CLASSES = 8;
    localparam int SCORE_WIDTH = 16;
    localparam int DATA_W      = ((MAX_CLASSES * SCORE_WIDTH + 7) / 8) * 8;
    localparam int LATENCY     = 2;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RAND_PHASES = 11;
    localparam int PHASE_ITEMS = 105;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 250;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [DATA_W-1:0]            s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [7:0]                   m_tdata;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [3:0]                   paddr = '0;
    logic [tcal_pkg::CFG_W-1:0]   pwdata = '0;
    logic [tcal_pkg::CFG_W-1:0]   prdata;
    logic                         pready;

    // Copy of the register file as the predictor sees it.
    logic signed [15:0]  thr_setting = 16'sd16384;
    logic [3:0]          count_setting = 4'd8;
    logic                bg_setting = 1'b0;
    logic [7:0]          mask_setting = 8'h00;

    logic [DATA_W-1:0]   pixel_queue[$];
    logic [3:0]          expected_labels[$];
    int                  mismatches = 0;
    int                  labels_seen = 0;

    thresholded_class_argmax_labeler_top #(
        .MAX_CLASSES(MAX_CLASSES),
        .SCORE_WIDTH(SCORE_WIDTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Label of one pixel under the current register copy. Later ties win,
    // and the running best starts at class 0 even when class 0 is ignored.
    function automatic logic [3:0] predict_label(input logic [DATA_W-1:0] px);
        logic signed [15:0] best;
        logic signed [15:0] s;
        int n;
        int first;
        int winner;
        int below;
        bit found;
        n = count_setting;
        if (n > MAX_CLASSES) begin
            n = MAX_CLASSES;
        end
        first = (bg_setting && n > 1) ? 1 : 0;
        best = px[15:0];
        winner = 0;
        below = 0;
        found = 1'b0;
        for (int j = first; j < n; j++) begin
            if (!mask_setting[j]) begin
                s = px[SCORE_WIDTH*j +: SCORE_WIDTH];
                if (s > thr_setting && s >= best) begin
                    best = s;
                    winner = j;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            return 4'd0;
        end
        for (int j = 0; j < winner; j++) begin
            if (!mask_setting[j]) begin
                below++;
            end
        end
        return 4'(below + 1 - first);
    endfunction

    // One score, biased toward the threshold and the extremes.
    function automatic logic [15:0] pick_score();
        int v;
        int t;
        int r;
        int mode;
        t = thr_setting;
        mode = $urandom_range(0, 99);
        if (mode < 30) begin
            v = $signed(16'($urandom));
        end else if (mode < 65) begin
            r = $urandom_range(0, 80);
            v = t + r - 40;
        end else if (mode < 80) begin
            case ($urandom_range(0, 3))
                0: v = -32768;
                1: v = 32767;
                2: v = t;
                default: v = t + 1;
            endcase
        end else begin
            r = $urandom_range(0, 300);
            v = 32767 - r;
        end
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    // A random pixel; some of them carry tied scores.
    function automatic logic [DATA_W-1:0] random_pixel();
        logic [DATA_W-1:0] px;
        int a;
        int b;
        px = '0;
        for (int k = 0; k < MAX_CLASSES; k++) begin
            px[SCORE_WIDTH*k +: SCORE_WIDTH] = pick_score();
        end
        if ($urandom_range(0, 9) < 4) begin
            a = $urandom_range(0, MAX_CLASSES - 1);
            repeat ($urandom_range(1, 3)) begin
                b = $urandom_range(0, MAX_CLASSES - 1);
                px[SCORE_WIDTH*b +: SCORE_WIDTH] = px[SCORE_WIDTH*a +: SCORE_WIDTH];
            end
        end
        return px;
    endfunction

    // Register write: setup cycle, then access cycle until pready.
    task automatic cfg_write(input tcal_pkg::reg_idx_t idx,
                             input logic [tcal_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tcal_pkg::REG_THRESHOLD:   thr_setting = value[15:0];
            tcal_pkg::REG_CLASS_COUNT: count_setting = value[3:0];
            tcal_pkg::REG_BACKGROUND:  bg_setting = value[0];
            default:                   mask_setting = value[7:0];
        endcase
    endtask

    task automatic set_config(input int thr, input int cnt, input int bg, input int mask);
        cfg_write(tcal_pkg::REG_THRESHOLD, 32'(thr));
        cfg_write(tcal_pkg::REG_CLASS_COUNT, 32'(cnt));
        cfg_write(tcal_pkg::REG_BACKGROUND, 32'(bg));
        cfg_write(tcal_pkg::REG_IGNORE_MASK, 32'(mask));
    endtask

    // Holds the sender back until every label is in, then lets the pipe settle.
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || expected_labels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // Stimulus: directed pixels under chosen settings, then random phases.
    initial begin
        logic [DATA_W-1:0] px;
        int thr;
        int cnt;
        int bg;
        int mask;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: extremes, one class alone, threshold boundary.
        pixel_queue.push_back({MAX_CLASSES{16'h8000}});
        pixel_queue.push_back({MAX_CLASSES{16'h7fff}});
        for (int k = 0; k < MAX_CLASSES; k++) begin
            px = {MAX_CLASSES{16'h8000}};
            px[SCORE_WIDTH*k +: SCORE_WIDTH] = 16'h7fff;
            pixel_queue.push_back(px);
        end
        px = {MAX_CLASSES{16'h8000}};
        px[SCORE_WIDTH*3 +: SCORE_WIDTH] = 16'd16384;
        pixel_queue.push_back(px);
        px[SCORE_WIDTH*3 +: SCORE_WIDTH] = 16'd16385;
        pixel_queue.push_back(px);
        pixel_queue.push_back({MAX_CLASSES{16'h5555}});
        pixel_queue.push_back({MAX_CLASSES{16'haaaa}});
        wait_drained();

        // Background with a single class: class 0 can win and is labeled 1.
        set_config(0, 1, 1, 8'h00);
        pixel_queue.push_back({MAX_CLASSES{16'h7fff}});
        wait_drained();

        // Ignored class 0 still seeds the running best.
        set_config(0, 8, 1, 8'h01);
        px = {MAX_CLASSES{16'd100}};
        px[15:0] = 16'h7fff;
        pixel_queue.push_back(px);
        px[SCORE_WIDTH*5 +: SCORE_WIDTH] = 16'h7fff;
        pixel_queue.push_back(px);
        wait_drained();

        // Zero classes: nothing is scanned.
        set_config(-32768, 0, 0, 8'h00);
        pixel_queue.push_back({MAX_CLASSES{16'h7fff}});
        wait_drained();

        // Count above the lane count is clamped.
        set_config(-32768, 15, 0, 8'ha5);
        pixel_queue.push_back(random_pixel());
        pixel_queue.push_back({MAX_CLASSES{16'h7fff}});
        wait_drained();

        // Random phases, each under its own settings.
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin thr = -32768; cnt = 8;  bg = 0; mask = 8'h00; end
                1: begin thr = 32767;  cnt = 8;  bg = 1; mask = 8'h00; end
                2: begin thr = 0;      cnt = 1;  bg = 1; mask = 8'h00; end
                3: begin thr = 256;    cnt = 2;  bg = 1; mask = 8'h00; end
                4: begin thr = 16384;  cnt = 8;  bg = 0; mask = 8'hff; end
                5: begin thr = -256;   cnt = 15; bg = 0; mask = $urandom_range(0, 255); end
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        thr = $urandom_range(0, 4000);
                        thr = thr - 2000;
                    end else begin
                        thr = $signed(16'($urandom));
                    end
                    if ($urandom_range(0, 9) < 7) begin
                        cnt = $urandom_range(1, 8);
                    end else begin
                        cnt = $urandom_range(0, 15);
                    end
                    bg = $urandom_range(0, 1);
                    if ($urandom_range(0, 1) == 0) begin
                        mask = $urandom_range(0, 255);
                    end else begin
                        mask = 1 << $urandom_range(0, 7);
                    end
                end
            endcase
            set_config(thr, cnt, bg, mask);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pixel_queue.push_back(random_pixel());
            end
            wait_drained();
        end

        repeat (4 * LATENCY) @(posedge aclk);
        if (mismatches == 0 && expected_labels.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Pixel driver: bursts of random length with random gaps between them.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        logic nxt_valid;
        nxt_valid = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_labels.push_back(predict_label(s_tdata));
                void'(pixel_queue.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                             : $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                end
            end
            // A request that is not taken stays on the bus unchanged.
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pixel_queue.size() != 0) begin
                    nxt_valid = 1'b1;
                    s_tdata <= pixel_queue[0];
                end
                s_tvalid <= nxt_valid;
            end
        end
    end

    // Label receiver: its own stall pattern, one long hold-off, and the check.
    int  hold_left = 0;
    int  run_left = 0;
    bit  rx_go = 1'b0;

    always @(posedge aclk) begin
        logic [3:0] want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_labels.size() == 0) begin
                    $error("label: expected none, actual %0d", m_tdata[3:0]);
                    mismatches++;
                end else begin
                    want = expected_labels.pop_front();
                    if (m_tdata[3:0] !== want) begin
                        $error("label: expected %0d, actual %0d", want, m_tdata[3:0]);
                        mismatches++;
                    end
                end
                labels_seen++;
                if (labels_seen == HOLD_AFTER) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (run_left <= 0) begin
                    rx_go = !rx_go;
                    if (rx_go) begin
                        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                               : $urandom_range(1, 30);
                    end else begin
                        run_left = $urandom_range(1, 6);
                    end
                end else begin
                    run_left--;
                end
                m_tready <= rx_go;
            end
        end
    end

    // Watchdog: too long without any request, label or register write.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
